### src/rmf_pkg.sv
// Shared types and constants for the running median filter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rmf_pkg;

   localparam int DATA_W         = 10;
   localparam int WINDOW_DEFAULT = 16;

   typedef logic [DATA_W-1:0] data_type;

   // Walk marker carried by the entry that was just rewritten.
   typedef struct packed {
      logic token;
      logic up;
      logic dn;
   } tag_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      data_type value;
      tag_type  tag;
   } entry_type;

   // Sequencer strobes to every cell.
   typedef struct packed {
      logic load;
      logic walk;
   } ctl_type;

endpackage

`default_nettype wire

### src/rmf_if.sv
// Handshake interfaces for the sample and median channels.
// Depends on rmf_pkg for the data type.
`timescale 1ns / 1ps
`default_nettype none

interface rmf_req_if import rmf_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface rmf_rsp_if import rmf_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type median;

   modport source (output valid, output median, input ready);
   modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

### src/running_median_filter.sv
// Running median filter top level: sequencer, chain of rank cells, output register.
// Depends on rmf_pkg, rmf_if (rmf_req_if, rmf_rsp_if) and rmf_cell.
//
// Usage:
//   req_if carries one 10-bit sample per transaction (valid && ready).
//   rsp_if returns one median per sample, in order, from a holding register.
//   The window holds the last WINDOW samples. A chain of WINDOW cells keeps
//   them sorted ascending; cell k is rank k and also records which window
//   slot it holds. A new sample overwrites the oldest slot's cell in place,
//   then that cell walks up or down by one neighbor swap per cycle until
//   the chain is sorted again. The median is read from cell WINDOW/2.
// Sequence: after accept the sequencer goes to ST_LOAD, which writes the sample,
//   then to ST_WALK for the swap walk; once the chain settles it captures the
//   median into the holding register. A walk makes at most WINDOW - 1 swaps.
// Throughput: one sample at a time; req ready is high only between samples.
//   The next sample can be taken the cycle after capture.
//   A sample may be accepted while the previous median still waits.
// Reset (synchronous, active high): window all zero, cell k owns slot k,
//   write slot zero, so the first sample lands in slot 1. No sweep needed.
// Stall: if rsp is still full when a walk finishes, the filter holds the
//   sorted chain and waits; no sample is accepted until the median is out.
`timescale 1ns / 1ps
`default_nettype none

module running_median_filter import rmf_pkg::*; #(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   rmf_req_if.sink   req_if,
   rmf_rsp_if.source rsp_if
);

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int MID    = WINDOW / 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_HOLD
   } state_type;

   state_type         state_ff;
   logic [SLOT_W-1:0] wslot_ff;
   data_type          sample_ff;
   logic              rsp_valid_ff;
   data_type          median_ff;

   entry_type         ent  [WINDOW];
   logic [SLOT_W-1:0] slot [WINDOW];
   logic [WINDOW-1:0] sup, sdn, tokens;
   ctl_type           ctl;
   logic              any_swap, req_fire, out_free, capture;

   // Edge stand-ins: strict compares against these never pass.
   localparam entry_type LO_EDGE = '{value: '0, tag: '0};
   localparam entry_type HI_EDGE = '{value: '1, tag: '0};

   assign ctl.load = (state_ff == ST_LOAD);
   assign ctl.walk = (state_ff == ST_WALK);

   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      entry_type         lo_e, hi_e;
      logic [SLOT_W-1:0] lo_s, hi_s;
      logic              lo_up, hi_dn;

      if (k == 0) begin : g_lo_edge
         assign lo_e  = LO_EDGE;
         assign lo_s  = '0;
         assign lo_up = 1'b0;
      end else begin : g_lo
         assign lo_e  = ent[k-1];
         assign lo_s  = slot[k-1];
         assign lo_up = sup[k-1];
      end

      if (k == WINDOW - 1) begin : g_hi_edge
         assign hi_e  = HI_EDGE;
         assign hi_s  = '0;
         assign hi_dn = 1'b0;
      end else begin : g_hi
         assign hi_e  = ent[k+1];
         assign hi_s  = slot[k+1];
         assign hi_dn = sdn[k+1];
      end

      rmf_cell #(.SLOT_W(SLOT_W)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .rst_slot   (SLOT_W'(k)),
         .wr_slot    (wslot_ff),
         .wr_value   (sample_ff),
         .lo_entry   (lo_e),
         .lo_slot    (lo_s),
         .lo_swap_up (lo_up),
         .hi_entry   (hi_e),
         .hi_slot    (hi_s),
         .hi_swap_dn (hi_dn),
         .entry      (ent[k]),
         .slot       (slot[k]),
         .swap_up    (sup[k]),
         .swap_dn    (sdn[k])
      );

      assign tokens[k] = ent[k].tag.token;
   end

   assign any_swap = (|sup) || (|sdn);
   assign req_fire = req_if.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   // Chain settled and the result register can take the median.
   assign capture  = (state_ff == ST_WALK || state_ff == ST_HOLD) && !any_swap && out_free;

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wslot_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready && !capture) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  sample_ff <= req_if.sample;
                  wslot_ff  <= (wslot_ff == SLOT_W'(WINDOW - 1)) ? '0
                                                                  : wslot_ff + 1'b1;
                  state_ff  <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_WALK;
            end
            ST_WALK, ST_HOLD: begin
               if (!any_swap) begin
                  if (out_free) begin
                     median_ff    <= ent[MID].value;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_HOLD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.median = median_ff;

   // Exactly one walking entry while the chain is being re-sorted.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> $onehot(tokens))
      else $error("walk without a single token");

   // The chain never swaps outside the walk phase.
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_WALK) |-> !any_swap)
      else $error("swap outside walk");

   // An accepted sample is loaded on the next cycle.
   a_load: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff == ST_LOAD))
      else $error("accept not followed by load");

   // A captured median is the middle rank of the settled chain.
   a_capture: assert property (@(posedge clock) disable iff (reset)
      capture |=> (rsp_valid_ff && median_ff == $past(ent[MID].value)))
      else $error("median capture mismatch");

endmodule

`default_nettype wire

### src/rmf_cell.sv
// One rank position of the sorted chain: value, owning slot and walk tag.
// Depends on rmf_pkg; swaps contents with a neighbor on request.
`timescale 1ns / 1ps
`default_nettype none

module rmf_cell import rmf_pkg::*; #(
   parameter int SLOT_W = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_type           ctl,
   input  wire logic [SLOT_W-1:0] rst_slot,
   input  wire logic [SLOT_W-1:0] wr_slot,
   input  wire data_type          wr_value,
   input  wire entry_type         lo_entry,
   input  wire logic [SLOT_W-1:0] lo_slot,
   input  wire logic              lo_swap_up,
   input  wire entry_type         hi_entry,
   input  wire logic [SLOT_W-1:0] hi_slot,
   input  wire logic              hi_swap_dn,
   output      entry_type         entry,
   output      logic [SLOT_W-1:0] slot,
   output      logic              swap_up,
   output      logic              swap_dn
);

   entry_type         entry_ff, entry_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // Only the token holder asks; neighbors are strict-compare stops.
   assign swap_up = ctl.walk && entry_ff.tag.token && entry_ff.tag.up &&
                    (hi_entry.value < entry_ff.value);
   assign swap_dn = ctl.walk && entry_ff.tag.token && entry_ff.tag.dn &&
                    (lo_entry.value > entry_ff.value);

   always_comb begin
      entry_in = entry_ff;
      slot_in  = slot_ff;
      if (ctl.load) begin
         entry_in.tag = '0;
         if (slot_ff == wr_slot) begin
            entry_in.value     = wr_value;
            entry_in.tag.token = 1'b1;
            entry_in.tag.up    = entry_ff.value < wr_value;
            entry_in.tag.dn    = entry_ff.value > wr_value;
         end
      end else if (lo_swap_up || swap_dn) begin
         entry_in = lo_entry;
         slot_in  = lo_slot;
      end else if (hi_swap_dn || swap_up) begin
         entry_in = hi_entry;
         slot_in  = hi_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         slot_ff  <= rst_slot;
      end else begin
         entry_ff <= entry_in;
         slot_ff  <= slot_in;
      end
   end

   assign entry = entry_ff;
   assign slot  = slot_ff;

endmodule

`default_nettype wire

### tb/sv/running_median_filter_tb.sv
// Self-checking testbench for running_median_filter: directed and shaped random samples,
// an in-bench sliding-window rank predictor, and random idling on both channels.
// Depends on rmf_pkg, rmf_if (rmf_req_if, rmf_rsp_if) and the running_median_filter RTL.
`timescale 1ns / 1ps
`default_nettype none

module running_median_filter_tb;
   import rmf_pkg::*;

   localparam int WIN        = WINDOW_DEFAULT;
   localparam int SLOT_W     = $clog2(WIN);
   // Walk is at most WIN - 1 swaps plus load, settle and output register.
   localparam int DRAIN_WAIT = WIN + 8;
   // Cycles with no transaction on either channel before the run is called hung.
   localparam int HANG_LIMIT = 2000;

   typedef logic [SLOT_W-1:0] slot_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmf_req_if req_if ();
   rmf_rsp_if rsp_if ();

   running_median_filter u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: window contents, rank order (slot per rank, ascending
   // by value) and the write slot. Mirrors the block's reset values.
   // ---------------------------------------------------------------------
   data_type window_vals [WIN];
   slot_type rank_slot   [WIN];
   slot_type write_slot;

   data_type sample_queue [$];   // samples waiting for the driver
   data_type median_queue [$];   // medians owed by the block, oldest first

   int  send_idle_pct = 38;
   int  recv_idle_pct = 61;
   int  error_count   = 0;
   int  quiet_cycles  = 0;
   bit  req_fire      = 1'b0;    // sample transaction at the last rising edge

   // Advance the write slot, overwrite the oldest sample, restore rank order by
   // adjacent swaps and return the value at the middle rank.
   function automatic data_type slide_window(data_type smp);
      data_type old_val;
      slot_type tmp;
      int       pos;
      write_slot = (write_slot == slot_type'(WIN - 1)) ? '0 : write_slot + 1'b1;
      old_val = window_vals[write_slot];
      window_vals[write_slot] = smp;
      // Find the rank that holds the rewritten slot; the lowest matching rank wins.
      pos = 0;
      for (int i = WIN - 1; i >= 0; i--)
         if (rank_slot[i] == write_slot) pos = i;
      // Move past strictly smaller (up) or strictly larger (down) neighbors,
      // stopping at an equal value. Equal old and new value: no move.
      if (old_val < smp) begin
         while (pos + 1 < WIN && window_vals[rank_slot[pos + 1]] < smp) begin
            tmp = rank_slot[pos];
            rank_slot[pos] = rank_slot[pos + 1];
            rank_slot[pos + 1] = tmp;
            pos++;
         end
      end else if (old_val > smp) begin
         // Downward walk may reach rank 0.
         while (pos > 0 && window_vals[rank_slot[pos - 1]] > smp) begin
            tmp = rank_slot[pos];
            rank_slot[pos] = rank_slot[pos - 1];
            rank_slot[pos - 1] = tmp;
            pos--;
         end
      end
      return window_vals[rank_slot[WIN / 2]];
   endfunction

   // Shaped random traffic: full-range values in four of ten runs, plus runs that stress
   // ties (narrow bands, constants), long walks (ramps) and the extremes.
   task automatic queue_burst(input int count);
      int       mode;
      int       run_len;
      int       step;
      data_type base;
      data_type val;
      while (count > 0) begin
         mode    = $urandom_range(9);
         run_len = $urandom_range(40, 1);
         if (run_len > count) run_len = count;
         base = data_type'($urandom_range(1023));
         step = $urandom_range(12, 1);
         for (int k = 0; k < run_len; k++) begin
            case (mode)
               0, 1, 2, 3: val = data_type'($urandom_range(1023));
               4, 5:       val = data_type'(int'(base) + int'($urandom_range(6)) - 3);
               6:          val = data_type'(int'(base) + step * k);
               7:          val = data_type'(int'(base) - step * k);
               8:          val = base;
               default:    val = $urandom_range(1) ? data_type'(1023) : data_type'(0);
            endcase
            sample_queue.push_back(val);
         end
         count -= run_len;
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: inputs move on the falling edge. Valid holds until the sample
   // is taken; a new one is offered only after a transaction or while idle.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid  <= 1'b0;
         req_if.sample <= '0;
      end else if (!req_if.valid || req_fire) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid  <= 1'b1;
            req_if.sample <= sample_queue.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge. An accepted sample
   // runs the predictor; an accepted median is checked against the oldest
   // expectation. Also runs the hang watchdog.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      data_type want;
      if (reset) begin
         for (int i = 0; i < WIN; i++) begin
            window_vals[i] = '0;
            rank_slot[i]   = slot_type'(i);
         end
         write_slot = '0;
         req_fire   = 1'b0;
      end else begin
         req_fire = req_if.valid && req_if.ready;
         if (req_fire)
            median_queue.push_back(slide_window(req_if.sample));
         if (rsp_if.valid && rsp_if.ready) begin
            if (median_queue.size() == 0) begin
               $error("median: unexpected transaction, actual %0d", rsp_if.median);
               error_count++;
            end else begin
               want = median_queue.pop_front();
               if (rsp_if.median !== want) begin
                  $error("median: expected %0d, actual %0d", want, rsp_if.median);
                  error_count++;
               end
            end
         end
      end
      if (req_fire || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
         $error("watchdog: no transaction for %0d cycles", HANG_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: reset, then three phases of traffic (receiver-heavy idling,
   // sender-heavy idling, none). Each phase drains completely before the
   // next starts, so the sender sits idle until every median is back.
   // ---------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: fill the window with one value (first sample walks from the
      // all-zero window to the top), then a new minimum that walks down to
      // rank 0, a maximum that walks to the top, an equal rewrite that must
      // not move, and alternating bit patterns.
      for (int i = 0; i < WIN; i++)
         sample_queue.push_back(data_type'(500));
      sample_queue.push_back(data_type'(1));
      sample_queue.push_back(data_type'(1023));
      sample_queue.push_back(data_type'(500));
      sample_queue.push_back(data_type'(10'h155));
      sample_queue.push_back(data_type'(10'h2AA));
      sample_queue.push_back(data_type'(0));

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 61;
            end
            1: begin
               send_idle_pct = 61;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         queue_burst(phase == 0 ? 610 : 640);
         while (sample_queue.size() != 0 || req_if.valid || median_queue.size() != 0)
            @(posedge clock);
      end

      // Let any late or extra result show up before the verdict.
      repeat (DRAIN_WAIT) @(posedge clock);
      if (median_queue.size() != 0) begin
         $error("median: %0d expected results never arrived", median_queue.size());
         error_count++;
      end
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
src/rmf_pkg.sv
src/rmf_if.sv
src/rmf_cell.sv
src/running_median_filter.sv
tb/sv/running_median_filter_tb.sv
